>>> hw/rtl/ss1d_pkg.sv
// Package with the byte codes, table lookups and result type of the scan code set 1 decoder.
`timescale 1ns / 1ps
`default_nettype none
package ss1d_pkg;

  localparam logic [7:0] BYTE_ACK    = 8'hFA;
  localparam logic [7:0] BYTE_RESEND = 8'hFE;
  localparam logic [7:0] BYTE_EXT    = 8'hE0;
  localparam logic [7:0] BYTE_PAUSE  = 8'hE1;
  localparam logic [7:0] BYTE_PRT1   = 8'h2A;
  localparam logic [7:0] BYTE_PRT2   = 8'h37;
  localparam logic [7:0] BYTE_BRK1   = 8'h46;
  localparam logic [7:0] BYTE_BRK2   = 8'hC6;
  localparam logic [7:0] BYTE_PAU1   = 8'h1D;
  localparam logic [7:0] BYTE_PAU2   = 8'h45;
  localparam logic [7:0] BYTE_PAU3   = 8'h9D;
  localparam logic [7:0] BYTE_PAU4   = 8'hC5;

  localparam logic [1:0] SK_NONE  = 2'd0;
  localparam logic [1:0] SK_PRINT = 2'd1;
  localparam logic [1:0] SK_BREAK = 2'd2;
  localparam logic [1:0] SK_PAUSE = 2'd3;

  localparam int OUT_TDATA_W = 16;

  typedef struct packed {
    logic       valid;
    logic [1:0] special_key;
    logic [6:0] scan_code;
    logic       extended;
    logic       key_up;
  } ss1d_result_t;

  function automatic logic plain_listed(input logic [6:0] code);
    plain_listed = ((code >= 7'h01) && (code <= 7'h53)) || (code == 7'h57) ||
                   (code == 7'h58);
  endfunction

  function automatic logic ext_listed(input logic [6:0] code);
    case (code)
      7'h1C, 7'h1D, 7'h35, 7'h37, 7'h38, 7'h47, 7'h48, 7'h49,
      7'h4B, 7'h4D, 7'h4F, 7'h50, 7'h51, 7'h52, 7'h53: ext_listed = 1'b1;
      default: ext_listed = 1'b0;
    endcase
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/ss1d_parser.sv
// Sequence parser: holds the parse state and decodes one byte into at most one key event.
`timescale 1ns / 1ps
`default_nettype none
module ss1d_parser
  import ss1d_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         step,
  input  wire logic [7:0]   scan_byte,
  output ss1d_result_t      res
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXT, ST_PRT1, ST_PRT2, ST_BRK1, ST_BRK2,
    ST_PAU1, ST_PAU2, ST_PAU3, ST_PAU4, ST_PAU5
  } state_t;

  state_t parse_state_r;
  state_t parse_state_nxt;

  logic [6:0] code;
  assign code = scan_byte[6:0];

  always_comb begin
    parse_state_nxt = ST_IDLE;
    res             = '0;
    case (parse_state_r)
      ST_EXT: begin
        if (scan_byte == BYTE_PRT1) begin
          parse_state_nxt = ST_PRT1;
        end else if (scan_byte == BYTE_BRK1) begin
          parse_state_nxt = ST_BRK1;
        end else if (scan_byte == BYTE_PAUSE) begin
          parse_state_nxt = ST_PAU1;
        end else begin
          res.valid       = ext_listed(code);
          res.key_up      = scan_byte[7];
          res.extended    = 1'b1;
          res.scan_code   = code;
        end
      end
      ST_PRT1: if (scan_byte == BYTE_EXT) parse_state_nxt = ST_PRT2;
      ST_PRT2: begin
        if (scan_byte == BYTE_PRT2) begin
          res.valid       = 1'b1;
          res.extended    = 1'b1;
          res.special_key = SK_PRINT;
        end
      end
      ST_BRK1: if (scan_byte == BYTE_EXT) parse_state_nxt = ST_BRK2;
      ST_BRK2: begin
        if (scan_byte == BYTE_BRK2) begin
          res.valid       = 1'b1;
          res.extended    = 1'b1;
          res.special_key = SK_BREAK;
        end
      end
      ST_PAU1: if (scan_byte == BYTE_PAU1) parse_state_nxt = ST_PAU2;
      ST_PAU2: if (scan_byte == BYTE_PAU2) parse_state_nxt = ST_PAU3;
      ST_PAU3: if (scan_byte == BYTE_PAUSE) parse_state_nxt = ST_PAU4;
      ST_PAU4: if (scan_byte == BYTE_PAU3) parse_state_nxt = ST_PAU5;
      ST_PAU5: begin
        if (scan_byte == BYTE_PAU4) begin
          res.valid       = 1'b1;
          res.special_key = SK_PAUSE;
        end
      end
      default: begin
        if (scan_byte == BYTE_ACK || scan_byte == BYTE_RESEND) begin
          parse_state_nxt = ST_IDLE;
        end else if (scan_byte == BYTE_EXT) begin
          parse_state_nxt = ST_EXT;
        end else if (scan_byte == BYTE_PAUSE) begin
          parse_state_nxt = ST_PAU1;
        end else begin
          res.valid       = plain_listed(code);
          res.key_up      = scan_byte[7];
          res.scan_code   = code;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parse_state_r <= ST_IDLE;
    end else if (step) begin
      parse_state_r <= parse_state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/scancode_set1_decoder.sv
// Top level of the scan code set 1 decoder: input register, parser and output register.
// A result word passes through the input register and the parser into the output register before it is on the output.
// Throughput: one word per cycle while the output is not stalled; the parser decides each byte combinationally.
// A byte that yields no key event leaves no word on the output.
// Reset (synchronous, active low) empties both registers and returns the parser to idle.
`timescale 1ns / 1ps
`default_nettype none
module scancode_set1_decoder
  import ss1d_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output      logic                   in_tready,
  input  wire logic [7:0]             in_tdata,   // [7:0] scan_byte
  output      logic                   out_tvalid,
  input  wire logic                   out_tready,
  output      logic [OUT_TDATA_W-1:0] out_tdata   // key_up, extended, scan_code, special_key
);

  logic         in_vld_r;
  logic [7:0]   in_byte_r;
  logic         out_vld_r;
  logic [10:0]  out_data_r;
  ss1d_result_t res;
  logic         advance;

  ss1d_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .scan_byte (in_byte_r),
    .res       (res)
  );

  assign advance   = in_vld_r && (!res.valid || !out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (advance && res.valid) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
    if (advance && res.valid) begin
      out_data_r <= {res.special_key, res.scan_code, res.extended, res.key_up};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_TDATA_W - 11){1'b0}}, out_data_r};

endmodule
`default_nettype wire
